// ----- design/cia_pkg.sv -----
// Shared types, codes and constants of the checked integer ALU.
package cia_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int W = DATA_WIDTH;

  localparam logic [2:0] FN_ADD = 3'd0;
  localparam logic [2:0] FN_SUB = 3'd1;
  localparam logic [2:0] FN_MUL = 3'd2;
  localparam logic [2:0] FN_DIV = 3'd3;
  localparam logic [2:0] FN_EQ  = 3'd4;

  localparam logic [2:0] TAG_INT = 3'd0;
  localparam logic [2:0] TAG_DBL = 3'd1;

  localparam logic [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] NEG_ONE = {W{1'b1}};
  localparam logic [W-1:0] POS_ONE = {{(W-1){1'b0}}, 1'b1};
  localparam logic [2*W-1:0] LIM_POS = {{(W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [2*W-1:0] LIM_NEG = {{W{1'b0}}, 1'b1, {(W-1){1'b0}}};

  typedef enum logic [2:0] {
    EXC_NONE, EXC_FLOAT, EXC_ABOVE, EXC_BELOW,
    EXC_DIVZERO, EXC_BADTYPE, EXC_CMP, EXC_BOUNDARY
  } exc_t;

  typedef enum logic [1:0] {K_DONE, K_MUL, K_DIV} kind_t;

  typedef struct packed {
    logic [2:0]         func;
    logic [2:0]         type_a;
    logic signed [31:0] value_a;
    logic [2:0]         type_b;
    logic signed [31:0] value_b;
  } op_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               is_boolean;
    logic [2:0]         exception;
  } res_t;

  typedef struct packed {
    logic           valid;
    kind_t          kind;
    logic           neg;
    logic           same;
    exc_t           exc;
    logic           isb;
    logic [W-1:0]   res;
    logic [W-1:0]   ua;
    logic [W-1:0]   ub;
    logic [2*W-1:0] acc;
  } stage_t;

endpackage

// ----- design/cia_front.sv -----
// Decode stage: type checks, add/sub/equal results, divide and multiply bound checks, operand magnitudes.
module cia_front import cia_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   in_valid,
  input  op_t    op,
  output stage_t stage
);

  stage_t s;
  logic [W-1:0] a, b, ma, mb;
  logic [W:0] sum, dif;

  always_comb begin
    a = op.value_a[W-1:0];
    b = op.value_b[W-1:0];
    ma = a[W-1] ? (~a + POS_ONE) : a;
    mb = b[W-1] ? (~b + POS_ONE) : b;
    sum = {a[W-1], a} + {b[W-1], b};
    dif = {a[W-1], a} - {b[W-1], b};
    s = '0;
    s.valid = in_valid;
    s.kind = K_DONE;
    s.exc = EXC_NONE;
    if (op.func == FN_EQ) begin
      if (op.type_a != op.type_b) begin
        s.isb = 1'b1;
      end else if (op.type_a == TAG_INT) begin
        s.isb = 1'b1;
        s.res = {{(W-1){1'b0}}, a == b};
      end else begin
        s.exc = EXC_CMP;
      end
    end else if (!(op.func inside {FN_ADD, FN_SUB, FN_MUL, FN_DIV})) begin
      s.exc = EXC_BADTYPE;
    end else if (op.type_a == TAG_DBL || op.type_b == TAG_DBL) begin
      s.exc = EXC_FLOAT;
    end else if (op.type_a != TAG_INT || op.type_b != TAG_INT) begin
      s.exc = EXC_BADTYPE;
    end else begin
      case (op.func)
        FN_ADD: begin
          if (sum[W:W-1] == 2'b01) s.exc = EXC_ABOVE;
          else if (sum[W:W-1] == 2'b10) s.exc = EXC_BELOW;
          else s.res = sum[W-1:0];
        end
        FN_SUB: begin
          if (dif[W:W-1] == 2'b01) s.exc = EXC_ABOVE;
          else if (dif[W:W-1] == 2'b10) s.exc = EXC_BELOW;
          else s.res = dif[W-1:0];
        end
        FN_MUL: begin
          if (a == '0 || b == '0) begin
            s.res = '0;
          end else if ((a == MIN_VAL && b != POS_ONE) || (b == MIN_VAL && a != POS_ONE)) begin
            s.exc = EXC_BOUNDARY;
          end else begin
            s.kind = K_MUL;
            s.neg = a[W-1] ^ b[W-1];
            s.same = ~(a[W-1] ^ b[W-1]);
            s.ua = ma;
            s.ub = mb;
          end
        end
        default: begin
          if (b == '0) begin
            s.exc = EXC_DIVZERO;
          end else if (a == MIN_VAL && b == NEG_ONE) begin
            s.exc = EXC_ABOVE;
          end else begin
            s.kind = K_DIV;
            s.neg = a[W-1] ^ b[W-1];
            s.ua = ma;
            s.ub = mb;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) stage.valid <= 1'b0;
    else if (en) stage <= s;
  end

endmodule

// ----- design/cia_step.sv -----
// One pipeline step: one shift-add multiply bit or one restoring divide bit.
module cia_step import cia_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  stage_t cur,
  output stage_t nxt
);

  stage_t n;
  logic [W:0] hi;
  logic [W:0] rem2;
  logic [W+1:0] diff;

  always_comb begin
    n = cur;
    hi = {1'b0, cur.acc[2*W-1:W]} + (cur.ub[0] ? {1'b0, cur.ua} : '0);
    rem2 = {cur.acc[W-1:0], cur.ua[W-1]};
    diff = {1'b0, rem2} - {2'b00, cur.ub};
    case (cur.kind)
      K_MUL: begin
        n.acc = {hi, cur.acc[W-1:1]};
        n.ub = {1'b0, cur.ub[W-1:1]};
      end
      K_DIV: begin
        if (!diff[W+1]) begin
          n.acc[W-1:0] = diff[W-1:0];
          n.ua = {cur.ua[W-2:0], 1'b1};
        end else begin
          n.acc[W-1:0] = rem2[W-1:0];
          n.ua = {cur.ua[W-2:0], 1'b0};
        end
      end
      default: n = cur;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) nxt.valid <= 1'b0;
    else if (en) nxt <= n;
  end

endmodule

// ----- design/cia_back.sv -----
// Final stage: product range check, sign fix-up and output register.
module cia_back import cia_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  stage_t cur,
  output logic   out_valid,
  output res_t   out
);

  res_t r;
  exc_t e;
  logic [W-1:0] v;
  logic [W-1:0] q;

  always_comb begin
    e = cur.exc;
    v = cur.res;
    q = cur.neg ? (~cur.ua + POS_ONE) : cur.ua;
    case (cur.kind)
      K_MUL: begin
        if (cur.acc > (cur.same ? LIM_POS : LIM_NEG)) begin
          e = cur.same ? EXC_ABOVE : EXC_BELOW;
        end else begin
          v = cur.neg ? (~cur.acc[W-1:0] + POS_ONE) : cur.acc[W-1:0];
        end
      end
      K_DIV: v = q;
      default: v = cur.res;
    endcase
    r.value = 32'(signed'(v));
    r.is_boolean = cur.isb && (e == EXC_NONE);
    r.exception = e;
    if (e != EXC_NONE) r.value = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= cur.valid;
    end
    if (en) out <= r;
  end

endmodule

// ----- design/checked_integer_alu_unit.sv -----
// Top level of the checked signed integer ALU.
// Operation channel: op_valid / op_stall carry one op_t transaction
// (func, operand tags and values). Result channel: res_valid / res_stall
// carry one res_t transaction (value, is_boolean, exception) per operation.
// A transaction is taken at a rising edge with valid high and stall low.
// The pipeline holds a decode stage, one stage per
// operand bit shared by the shift-add multiplier and the restoring divider,
// and the output stage. Throughput is one operation per cycle while the
// result channel is not stalled; the per-bit stage chain sets the latency.
// Results leave in operation order. When the receiver stalls a valid
// result, the whole pipeline holds and op_stall is raised in the same
// cycle; nothing is lost or repeated.
// Synchronous reset rst clears all stage valid bits; no result is pending
// after reset.
module checked_integer_alu_unit import cia_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic op_valid,
  output logic op_stall,
  input  op_t  op,
  output logic res_valid,
  input  logic res_stall,
  output res_t res
);

  logic en;
  stage_t pipe [W+1];

  assign en = !(res_valid && res_stall);
  assign op_stall = !en;

  cia_front u_front (
    .clk(clk), .rst(rst), .en(en), .in_valid(op_valid), .op(op), .stage(pipe[0])
  );

  for (genvar i = 0; i < W; i++) begin : g_step
    cia_step u_step (
      .clk(clk), .rst(rst), .en(en), .cur(pipe[i]), .nxt(pipe[i+1])
    );
  end

  cia_back u_back (
    .clk(clk), .rst(rst), .en(en), .cur(pipe[W]), .out_valid(res_valid), .out(res)
  );

  a_exc_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.exception != EXC_NONE |-> res.value == 0 && !res.is_boolean)
    else $error("exception result not cleared");

  a_bool_val: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.is_boolean |-> res.value == 0 || res.value == 1)
    else $error("boolean result out of range");

  a_stall_link: assert property (@(posedge clk)
    op_stall == (res_valid && res_stall))
    else $error("input stall not tied to output stall");

  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

endmodule
